// ===== design/pnpf_pkg.sv =====
// Shared types and constants of the periodic neighbour pair finder.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none
package pnpf_pkg;

  localparam int POS_W   = 32;
  localparam int LEN_W   = 31;
  localparam int FLD_W   = 6;
  localparam int DIST_W  = 31;
  localparam int SUM_W   = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CFG_BOX_X  = 2'd0;
  localparam logic [1:0] CFG_BOX_Y  = 2'd1;
  localparam logic [1:0] CFG_BOX_Z  = 2'd2;
  localparam logic [1:0] CFG_CUTOFF = 2'd3;

  typedef enum logic [1:0] {
    ST_PAIR = 2'd0,
    ST_NONE = 2'd1,
    ST_OVF  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TK_PAIR = 2'd0,
    TK_END  = 2'd1,
    TK_OVF  = 2'd2,
    TK_FULL = 2'd3
  } tok_kind_t;

  typedef struct packed {
    logic [LEN_W-1:0] box_x;
    logic [LEN_W-1:0] box_y;
    logic [LEN_W-1:0] box_z;
    logic [LEN_W-1:0] cutoff;
  } cfg_t;

  typedef struct packed {
    tok_kind_t        kind;
    logic [FLD_W-1:0] ea;
    logic [FLD_W-1:0] na;
    logic [SUM_W-1:0] sum;
  } tok_t;

  typedef struct packed {
    logic [FLD_W-1:0]  ea;
    logic [FLD_W-1:0]  na;
    logic [FLD_W-1:0]  es;
    logic [FLD_W-1:0]  ns;
    logic [DIST_W-1:0] distance;
    status_t           status;
    logic              eor;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } back_stat_t;

  typedef struct packed {
    logic clear;
  } front_ctl_t;

endpackage
`default_nettype wire

// ===== design/pnpf_fifo.sv =====
// Short token queue between the compare front end and the result back end.
// Depends on pnpf_pkg for the token type.
`default_nettype none
module pnpf_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pnpf_pkg::tok_t push_tok,
  input  wire logic          pop,
  output pnpf_pkg::tok_t     head_tok,
  output logic               full,
  output logic               empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pnpf_pkg::tok_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_tok = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/pnpf_front.sv =====
// Front end: accepts atoms, keeps the position store and sweeps stored atoms
// through a six-stage distance pipeline. Depends on pnpf_pkg.
`default_nettype none
module pnpf_front #(
  parameter int MAX_ATOMS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic                   in_first,
  input  wire logic [3*pnpf_pkg::POS_W-1:0] in_pos,
  input  wire pnpf_pkg::cfg_t         cfg,
  output logic                        push,
  output pnpf_pkg::tok_t              push_tok,
  input  wire logic                   q_full,
  input  wire logic                   q_empty,
  input  wire pnpf_pkg::back_stat_t   back_stat,
  output pnpf_pkg::front_ctl_t        ctl
);
  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam int PW = pnpf_pkg::POS_W;
  localparam int LW = pnpf_pkg::LEN_W;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_WAIT} state_t;

  state_t               state_r;
  logic [CW-1:0]        cnt_r;
  logic                 ovf_r;
  logic                 swept_r;
  logic [AW-1:0]        n_r, i_r;
  logic [3*PW-1:0]      p_r;
  logic [3*PW-1:0]      mem [MAX_ATOMS];
  logic [3*PW-1:0]      rd_q;
  logic [2*LW-1:0]      r2_r;

  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic [AW-1:0]        s1_i_r, s2_i_r, s3_i_r, s4_i_r, s5_i_r, s6_i_r;
  logic signed [33:0]   d2_r [3];
  logic signed [33:0]   d3_r [3];
  logic signed [33:0]   d4_r [3];
  logic [61:0]          sq5_r [3];
  logic [2:0]           ok5_r;
  logic [63:0]          sum6_r;
  logic                 ok6_r;

  logic                 accept, first_clr, busy, en, issue, push_pair, push_end;
  logic [CW-1:0]        eff_cnt;
  logic                 eff_ovf;
  logic [LW-1:0]        lens [3];
  logic signed [33:0]   d3_nxt [3];
  logic signed [33:0]   d4_nxt [3];
  logic [33:0]          abs5 [3];

  assign lens[0] = cfg.box_x;
  assign lens[1] = cfg.box_y;
  assign lens[2] = cfg.box_z;

  assign in_tready = (state_r == S_IDLE) && q_empty;
  assign accept    = in_tvalid && in_tready;
  assign first_clr = accept && in_first;
  assign ctl.clear = first_clr;
  assign eff_cnt   = in_first ? '0 : cnt_r;
  assign eff_ovf   = in_first ? 1'b0 : ovf_r;

  assign busy      = s1_v_r || s2_v_r || s3_v_r || s4_v_r || s5_v_r || s6_v_r;
  assign push_pair = s6_v_r && ok6_r && (sum6_r < {2'b00, r2_r});
  assign en        = !(push_pair && q_full);
  assign issue     = (state_r == S_SWEEP) && (i_r != n_r) && en;
  assign push_end  = (state_r == S_SWEEP) && (i_r == n_r) && !busy && !q_full;

  // One token source at a time: markers at accept, pairs, then the end mark.
  always_comb begin
    push          = 1'b0;
    push_tok.kind = pnpf_pkg::TK_PAIR;
    push_tok.ea   = pnpf_pkg::FLD_W'(s6_i_r);
    push_tok.na   = pnpf_pkg::FLD_W'(n_r);
    push_tok.sum  = sum6_r;
    if (accept && eff_ovf) begin
      push          = 1'b1;
      push_tok.kind = pnpf_pkg::TK_OVF;
    end else if (accept && (eff_cnt == CW'(MAX_ATOMS))) begin
      push          = 1'b1;
      push_tok.kind = pnpf_pkg::TK_FULL;
    end else if (push_pair && !q_full) begin
      push          = 1'b1;
    end else if (push_end) begin
      push          = 1'b1;
      push_tok.kind = pnpf_pkg::TK_END;
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= cfg.cutoff * cfg.cutoff;
  end

  always_ff @(posedge clk) begin
    if (accept && !eff_ovf && (eff_cnt != CW'(MAX_ATOMS))) begin
      mem[eff_cnt[AW-1:0]] <= in_pos;
    end
    if (en) begin
      rd_q <= mem[i_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      swept_r <= 1'b0;
      i_r     <= '0;
      n_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cnt_r <= eff_cnt;
            ovf_r <= eff_ovf;
            if (eff_ovf || (eff_cnt == CW'(MAX_ATOMS))) begin
              swept_r <= 1'b0;
              state_r <= S_WAIT;
            end else begin
              swept_r <= 1'b1;
              n_r     <= eff_cnt[AW-1:0];
              i_r     <= '0;
              state_r <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          if (issue) begin
            i_r <= i_r + 1'b1;
          end
          if (push_end) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (back_stat.done) begin
            if (back_stat.ovf) begin
              ovf_r <= 1'b1;
            end else if (swept_r) begin
              cnt_r <= CW'(n_r) + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold the position of the atom under test.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_r <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      if ($signed({d2_r[ax], 1'b0}) < -$signed({4'b0000, lens[ax]})) begin
        d3_nxt[ax] = d2_r[ax] + $signed({3'b000, lens[ax]});
      end else begin
        d3_nxt[ax] = d2_r[ax];
      end
      if ($signed({d3_r[ax], 1'b0}) > $signed({4'b0000, lens[ax]})) begin
        d4_nxt[ax] = d3_r[ax] - $signed({3'b000, lens[ax]});
      end else begin
        d4_nxt[ax] = d3_r[ax];
      end
      abs5[ax] = d4_r[ax][33] ? 34'(-d4_r[ax]) : 34'(d4_r[ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_i_r <= i_r;
      s2_i_r <= s1_i_r;
      s3_i_r <= s2_i_r;
      s4_i_r <= s3_i_r;
      s5_i_r <= s4_i_r;
      s6_i_r <= s5_i_r;
      for (int ax = 0; ax < 3; ax++) begin
        d2_r[ax]  <= $signed({{2{p_r[ax*PW+PW-1]}}, p_r[ax*PW +: PW]})
                   - $signed({{2{rd_q[ax*PW+PW-1]}}, rd_q[ax*PW +: PW]});
        d3_r[ax]  <= d3_nxt[ax];
        d4_r[ax]  <= d4_nxt[ax];
        sq5_r[ax] <= abs5[ax][30:0] * abs5[ax][30:0];
        ok5_r[ax] <= abs5[ax] < {3'b000, cfg.cutoff};
      end
      sum6_r <= {2'b00, sq5_r[0]} + {2'b00, sq5_r[1]} + {2'b00, sq5_r[2]};
      ok6_r  <= &ok5_r;
    end
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !busy && q_empty)
    else $error("front ready while work is in flight");
  ap_end_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    push_end |-> !s6_v_r && (i_r == n_r))
    else $error("end mark pushed before the sweep drained");
  ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push_pair && q_full) |=> s6_v_r && $stable(sum6_r))
    else $error("stalled pair lost");
endmodule
`default_nettype wire

// ===== design/pnpf_back.sv =====
// Back end: assigns list slots, takes the integer square root and drives the
// result register. Depends on pnpf_pkg.
`default_nettype none
module pnpf_back #(
  parameter int MAX_ATOMS = 64,
  parameter int NBR_LIMIT = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pnpf_pkg::tok_t        tok,
  input  wire logic                  q_empty,
  output logic                       pop,
  input  wire pnpf_pkg::front_ctl_t  ctl,
  output pnpf_pkg::back_stat_t       back_stat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pnpf_pkg::out_item_t        out_item
);
  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int NW = $clog2(NBR_LIMIT + 1);
  localparam int FW = pnpf_pkg::FLD_W;

  typedef enum logic [2:0] {B_POP, B_RD, B_CHK, B_SQRT, B_EMIT, B_DROP, B_DONE} state_t;

  state_t               state_r, ret_r;
  pnpf_pkg::tok_t       cur_r;
  pnpf_pkg::out_item_t  pend_r, emit_r, out_r;
  logic                 pend_v_r, out_v_r, ovf_item_r;
  logic [NW-1:0]        new_cnt_r, cnt_rd_r;
  logic [NW-1:0]        cnt_mem [MAX_ATOMS];
  logic [MAX_ATOMS-1:0] nv_r;
  logic [63:0]          rad_r;
  logic [31:0]          root_r;
  logic [34:0]          rem_r;
  logic [4:0]           it_r;

  logic [AW-1:0]        ei, ni;
  logic [NW-1:0]        ecnt;
  logic                 over, save_new;
  logic [34:0]          rem_sh, trial;
  logic [31:0]          root_nxt;
  logic [34:0]          rem_nxt;
  logic                 out_free;

  assign ei       = cur_r.ea[AW-1:0];
  assign ni       = cur_r.na[AW-1:0];
  assign ecnt     = nv_r[ei] ? cnt_rd_r : '0;
  assign over     = (ecnt >= NW'(NBR_LIMIT)) || (new_cnt_r >= NW'(NBR_LIMIT));
  // Keep the new atom's list length once its sweep has finished cleanly.
  assign save_new = (state_r == B_DONE) && (cur_r.kind == pnpf_pkg::TK_END);
  assign out_free = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_item  = out_r;
  assign pop = ((state_r == B_POP) || (state_r == B_DROP)) && !q_empty;
  assign back_stat.done = (state_r == B_DONE);
  assign back_stat.ovf  = ovf_item_r;

  // One restoring step: two radicand bits in, one root bit out.
  always_comb begin
    rem_sh = {rem_r[32:0], rad_r[63:62]};
    trial  = {1'b0, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[30:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_RD) begin
      cnt_rd_r <= cnt_mem[ei];
    end
    if ((state_r == B_CHK) && !over) begin
      cnt_mem[ei] <= ecnt + 1'b1;
    end else if (save_new) begin
      cnt_mem[ni] <= new_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= '0;
    end else if (ctl.clear) begin
      nv_r <= '0;
    end else if ((state_r == B_CHK) && !over) begin
      nv_r[ei] <= 1'b1;
    end else if (save_new) begin
      nv_r[ni] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_POP;
      ret_r      <= B_POP;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      ovf_item_r <= 1'b0;
      new_cnt_r  <= '0;
      it_r       <= '0;
    end else begin
      if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        B_POP: begin
          if (!q_empty) begin
            cur_r  <= tok;
            emit_r <= '{ea: '0, na: '0, es: '0, ns: '0, distance: '0,
                        status: pnpf_pkg::ST_NONE, eor: 1'b1};
            unique case (tok.kind)
              pnpf_pkg::TK_PAIR: begin
                if (pend_v_r) begin
                  emit_r   <= pend_r;
                  pend_v_r <= 1'b0;
                  ret_r    <= B_RD;
                  state_r  <= B_EMIT;
                end else begin
                  state_r <= B_RD;
                end
              end
              pnpf_pkg::TK_END: begin
                if (pend_v_r) begin
                  emit_r     <= pend_r;
                  emit_r.eor <= 1'b1;
                  pend_v_r   <= 1'b0;
                end else begin
                  emit_r.na <= tok.na;
                end
                ret_r   <= B_DONE;
                state_r <= B_EMIT;
              end
              pnpf_pkg::TK_OVF: begin
                emit_r.status <= pnpf_pkg::ST_OVF;
                ret_r         <= B_DONE;
                state_r       <= B_EMIT;
              end
              pnpf_pkg::TK_FULL: begin
                emit_r.status <= pnpf_pkg::ST_FULL;
                ret_r         <= B_DONE;
                state_r       <= B_EMIT;
              end
              default: state_r <= B_POP;
            endcase
          end
        end
        B_RD: state_r <= B_CHK;
        B_CHK: begin
          if (over) begin
            emit_r     <= '{ea: '0, na: cur_r.na, es: '0, ns: '0, distance: '0,
                            status: pnpf_pkg::ST_OVF, eor: 1'b1};
            ovf_item_r <= 1'b1;
            ret_r      <= B_DROP;
            state_r    <= B_EMIT;
          end else begin
            pend_r    <= '{ea: cur_r.ea, na: cur_r.na, es: FW'(ecnt), ns: FW'(new_cnt_r),
                           distance: '0, status: pnpf_pkg::ST_PAIR, eor: 1'b0};
            new_cnt_r <= new_cnt_r + 1'b1;
            rad_r     <= cur_r.sum;
            root_r    <= '0;
            rem_r     <= '0;
            it_r      <= '0;
            state_r   <= B_SQRT;
          end
        end
        B_SQRT: begin
          rad_r  <= {rad_r[61:0], 2'b00};
          root_r <= root_nxt;
          rem_r  <= rem_nxt;
          it_r   <= it_r + 1'b1;
          if (it_r == 5'd31) begin
            pend_r.distance <= root_nxt[pnpf_pkg::DIST_W-1:0];
            pend_v_r        <= 1'b1;
            state_r         <= B_POP;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            out_r   <= emit_r;
            out_v_r <= 1'b1;
            state_r <= ret_r;
          end
        end
        B_DROP: begin
          if (!q_empty && (tok.kind == pnpf_pkg::TK_END)) begin
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          ovf_item_r <= 1'b0;
          new_cnt_r  <= '0;
          state_r    <= B_POP;
        end
        default: state_r <= B_POP;
      endcase
    end
  end

  ap_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_r.status != pnpf_pkg::ST_PAIR)) |-> out_r.eor)
    else $error("marker result without end of run");
  ap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (nv_r == '0))
    else $error("neighbour counts not cleared");
  ap_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DONE) |-> !pend_v_r)
    else $error("pending pair left at end of item");
endmodule
`default_nettype wire

// ===== design/periodic_neighbour_pair_finder_unit.sv =====
// Top level of the periodic neighbour pair finder: config registers, front
// end, token queue, back end. Depends on pnpf_pkg, pnpf_front, pnpf_fifo, pnpf_back.
//
// Usage:
//  - in_*: one atom per item, tdata = {pos_z, pos_y, pos_x} (signed Q16.16),
//    tuser = first_atom (restart the set).
//  - out_*: one result per item; tdata holds indices, slots and distance,
//    tuser the status code, tlast marks the last result of an input item.
//  - cfg_*: register writes (box lengths x/y/z, cutoff), always ready; write
//    only while the block is idle.
//  - Each stored atom streams through a six-stage distance pipeline at one
//    atom per cycle unless a full token queue stalls it; every qualifying
//    pair then passes the back end (slot lookup plus a 32-step square root,
//    two bits per cycle). The next item is taken once all results have been
//    queued.
//  - A four-entry token queue parts the sweep from the back end; a full queue
//    stalls the pipeline, and a stalled receiver holds the result register.
//  - Synchronous reset clears counts, flags and handshakes; the position
//    store is not cleared and only written entries are read.
`default_nettype none
module periodic_neighbour_pair_finder_unit #(
  parameter int MAX_ATOMS = 64,
  parameter int NBR_LIMIT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,
  // in_tuser: first_atom [0]
  input  wire logic        in_tuser,
  // out_tdata: earlier_atom [5:0], new_atom [11:6], earlier_slot [17:12],
  //            new_slot [23:18], distance [54:24], zero [55]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);
  pnpf_pkg::cfg_t        cfg_r;
  pnpf_pkg::tok_t        push_tok, head_tok;
  pnpf_pkg::back_stat_t  back_stat;
  pnpf_pkg::front_ctl_t  ctl;
  pnpf_pkg::out_item_t   res;
  logic                  push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  // Apply register writes; reset restores the default box and cutoff.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_x  <= 31'd6553600;
      cfg_r.box_y  <= 31'd6553600;
      cfg_r.box_z  <= 31'd6553600;
      cfg_r.cutoff <= 31'd196608;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pnpf_pkg::CFG_BOX_X:  cfg_r.box_x  <= cfg_data;
        pnpf_pkg::CFG_BOX_Y:  cfg_r.box_y  <= cfg_data;
        pnpf_pkg::CFG_BOX_Z:  cfg_r.box_z  <= cfg_data;
        pnpf_pkg::CFG_CUTOFF: cfg_r.cutoff <= cfg_data;
        default:              cfg_r        <= cfg_r;
      endcase
    end
  end

  pnpf_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_first  (in_tuser),
    .in_pos    (in_tdata),
    .cfg       (cfg_r),
    .push      (push),
    .push_tok  (push_tok),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .back_stat (back_stat),
    .ctl       (ctl)
  );

  pnpf_fifo #(.DEPTH(pnpf_pkg::QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .full     (q_full),
    .empty    (q_empty)
  );

  pnpf_back #(.MAX_ATOMS(MAX_ATOMS), .NBR_LIMIT(NBR_LIMIT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (head_tok),
    .q_empty   (q_empty),
    .pop       (pop),
    .ctl       (ctl),
    .back_stat (back_stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {1'b0, res.distance, res.ns, res.es, res.na, res.ea};
  assign out_tuser = res.status;
  assign out_tlast = res.eor;
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for periodic_neighbour_pair_finder_unit: predicts pair
// lists with minimum-image distances and checks every result item in order.
// Depends on pnpf_pkg and the design files.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ATOMS = 64;
  localparam int NBRS  = 64;

  typedef struct {
    logic        first;
    logic [31:0] px, py, pz;
  } atom_item_t;

  typedef struct {
    logic [5:0]        ea, na, es, ns;
    logic [30:0]       distance;
    pnpf_pkg::status_t status;
    logic              eor;
  } pair_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  periodic_neighbour_pair_finder_unit uut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [30:0]  box_len [3];
  logic [30:0]  cutoff;
  logic signed [31:0] store_pos [ATOMS][3];
  int unsigned  nbr_count [ATOMS];
  int unsigned  stored_atoms;
  bit           set_overflowed;

  atom_item_t   pending_atoms[$];
  pair_result_t expected_pairs[$];
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic pair_result_t marker(pnpf_pkg::status_t st, logic [5:0] na);
    pair_result_t m;
    m = '{ea: '0, na: na, es: '0, ns: '0, distance: '0, status: st, eor: 1'b1};
    return m;
  endfunction

  // Work out every result one atom causes and update the pair lists.
  task automatic predict_pairs(atom_item_t a);
    longint p[3], d, l, r, ab;
    logic [63:0] sum, r2;
    int unsigned n, k;
    bit ok;
    pair_result_t pr;
    r = longint'(cutoff);
    r2 = 64'(r * r);
    k = 0;
    if (a.first) begin
      stored_atoms = 0;
      set_overflowed = 0;
      foreach (nbr_count[j]) nbr_count[j] = 0;
    end
    if (set_overflowed) begin
      expected_pairs.push_back(marker(pnpf_pkg::ST_OVF, 6'd0));
      return;
    end
    if (stored_atoms >= ATOMS) begin
      expected_pairs.push_back(marker(pnpf_pkg::ST_FULL, 6'd0));
      return;
    end
    p[0] = longint'($signed(a.px));
    p[1] = longint'($signed(a.py));
    p[2] = longint'($signed(a.pz));
    n = stored_atoms;
    for (int unsigned i = 0; i < n; i++) begin
      sum = '0;
      ok = 1;
      for (int ax = 0; ax < 3 && ok; ax++) begin
        l = longint'(box_len[ax]);
        d = p[ax] - longint'(store_pos[i][ax]);
        if (2 * d < -l) d = d + l;
        if (2 * d > l) d = d - l;
        ab = d < 0 ? -d : d;
        if (ab >= r) ok = 0;
        else begin
          sum = sum + 64'(ab * ab);
          if (sum >= r2) ok = 0;
        end
      end
      if (!ok) continue;
      if (nbr_count[i] >= NBRS || nbr_count[n] >= NBRS) begin
        set_overflowed = 1;
        expected_pairs.push_back(marker(pnpf_pkg::ST_OVF, n[5:0]));
        return;
      end
      pr = '{ea: i[5:0], na: n[5:0], es: nbr_count[i][5:0], ns: nbr_count[n][5:0],
             distance: 31'(floor_sqrt(sum)), status: pnpf_pkg::ST_PAIR, eor: 1'b0};
      expected_pairs.push_back(pr);
      nbr_count[i]++;
      nbr_count[n]++;
      k++;
    end
    store_pos[n][0] = 32'(p[0]);
    store_pos[n][1] = 32'(p[1]);
    store_pos[n][2] = 32'(p[2]);
    stored_atoms = n + 1;
    if (k == 0) expected_pairs.push_back(marker(pnpf_pkg::ST_NONE, n[5:0]));
    else expected_pairs[$].eor = 1'b1;
  endtask

  // Driver: present the oldest pending atom, predict on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_pairs('{first: in_tuser, px: in_tdata[31:0], py: in_tdata[63:32],
                        pz: in_tdata[95:64]});
        void'(pending_atoms.pop_front());
      end
      // hold a presented item until it is taken; otherwise maybe idle
      if (!(in_tvalid && !in_tready)) begin
        if (pending_atoms.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_atoms[0].first;
          in_tdata  <= {pending_atoms[0].pz, pending_atoms[0].py, pending_atoms[0].px};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    pair_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%0d tlast=%0b", $time,
                 out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        exp_r = expected_pairs.pop_front();
        if (out_tdata[5:0] !== exp_r.ea || out_tdata[11:6] !== exp_r.na ||
            out_tdata[17:12] !== exp_r.es || out_tdata[23:18] !== exp_r.ns ||
            out_tdata[54:24] !== exp_r.distance || out_tdata[55] !== 1'b0 ||
            out_tuser !== exp_r.status || out_tlast !== exp_r.eor) begin
          $display("%0t: mismatch expected ea=%0d na=%0d es=%0d ns=%0d dist=%0d st=%0d last=%0b",
                   $time, exp_r.ea, exp_r.na, exp_r.es, exp_r.ns, exp_r.distance,
                   exp_r.status, exp_r.eor);
          $display("%0t:          actual   ea=%0d na=%0d es=%0d ns=%0d dist=%0d st=%0d last=%0b",
                   $time, out_tdata[5:0], out_tdata[11:6], out_tdata[17:12],
                   out_tdata[23:18], out_tdata[54:24], out_tuser, out_tlast);
          errors++;
        end
      end
    end
  end

  // Write one register, then leave the channel idle before returning.
  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    unique case (idx)
      pnpf_pkg::CFG_BOX_X:  box_len[0] = val;
      pnpf_pkg::CFG_BOX_Y:  box_len[1] = val;
      pnpf_pkg::CFG_BOX_Z:  box_len[2] = val;
      pnpf_pkg::CFG_CUTOFF: cutoff = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_atoms.size() != 0 || in_tvalid || expected_pairs.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic add_atom(bit first, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pending_atoms.push_back('{first: first, px: x, py: y, pz: z});
  endtask

  // A cluster of atoms close together, so most pairs qualify.
  task automatic add_cluster(int count, int spread);
    logic [31:0] cx, cy, cz;
    cx = $urandom;
    cy = $urandom;
    cz = $urandom;
    for (int j = 0; j < count; j++)
      add_atom(j == 0, cx + $urandom_range(spread), cy + $urandom_range(spread),
               cz + $urandom_range(spread));
  endtask

  initial begin
    box_len = '{31'd6553600, 31'd6553600, 31'd6553600};
    cutoff = 31'd196608;
    stored_atoms = 0;
    set_overflowed = 0;
    foreach (nbr_count[j]) nbr_count[j] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, wrap in both directions, no pairs, zero box
    add_atom(1, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    add_atom(0, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    add_atom(0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    add_atom(1, 32'd10, 32'd0, 32'd0);
    add_atom(0, 32'd6553590, 32'd0, 32'd0);        // wraps to distance 20
    add_atom(0, -32'sd6553595, 32'd5, 32'd5);
    add_atom(0, 32'd100000, 32'd100000, 32'd0);
    wait_drained();

    write_reg(pnpf_pkg::CFG_BOX_X, 31'd0);
    write_reg(pnpf_pkg::CFG_BOX_Y, 31'h7fff_ffff);
    write_reg(pnpf_pkg::CFG_BOX_Z, 31'd65536);
    write_reg(pnpf_pkg::CFG_CUTOFF, 31'h7fff_ffff);
    add_atom(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_atom(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_atom(0, 32'h0, 32'h0, 32'h0);
    add_atom(0, 32'h1234_5678, 32'hedcb_a987, 32'h0000_8000);
    wait_drained();

    // zero cutoff: never a pair
    write_reg(pnpf_pkg::CFG_CUTOFF, 31'd0);
    add_atom(1, 32'd0, 32'd0, 32'd0);
    add_atom(0, 32'd0, 32'd0, 32'd0);
    wait_drained();

    // huge cutoff: every atom pairs; fill the store past its end
    write_reg(pnpf_pkg::CFG_CUTOFF, 31'h4000_0000);
    write_reg(pnpf_pkg::CFG_BOX_X, 31'd6553600);
    write_reg(pnpf_pkg::CFG_BOX_Y, 31'd6553600);
    write_reg(pnpf_pkg::CFG_BOX_Z, 31'd6553600);
    for (int j = 0; j < 66; j++) add_atom(j == 0, $urandom_range(65535), 0, 0);
    wait_drained();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 38 : 0;
      recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 38 : 0;
      write_reg(pnpf_pkg::CFG_BOX_X, 31'($urandom_range(13107200)));
      write_reg(pnpf_pkg::CFG_BOX_Y, 31'($urandom_range(13107200)));
      write_reg(pnpf_pkg::CFG_BOX_Z,
                (ph == 0) ? 31'h7fff_ffff : 31'($urandom_range(13107200)));
      write_reg(pnpf_pkg::CFG_CUTOFF, 31'($urandom_range(65536, 655360)));
      for (int c = 0; c < 2; c++) add_cluster($urandom_range(6, 14), $urandom_range(400000));
      for (int j = 0; j < 4; j++)
        add_atom($urandom_range(9) == 0, $urandom, $urandom, $urandom);
      wait_drained();
    end

    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// ===== periodic_neighbour_pair_finder_unit.f =====
design/pnpf_pkg.sv
design/pnpf_fifo.sv
design/pnpf_front.sv
design/pnpf_back.sv
design/periodic_neighbour_pair_finder_unit.sv
test/testbench.sv
